>>> hw/rtl/mesh_mailbox_ring_queues_top_defines.svh
// Assertion macros shared by the mailbox mesh RTL.
`ifndef MESH_MAILBOX_RING_QUEUES_TOP_DEFINES_SVH
`define MESH_MAILBOX_RING_QUEUES_TOP_DEFINES_SVH

// Check a property on each rising clock edge, skipped while reset is low.
`define MMRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define MMRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mmrq_pkg.sv
// Types, codes and helper functions of the mailbox mesh.
`default_nettype none

package mmrq_pkg;

    // default sizes
    localparam int DEF_NODES      = 4;
    localparam int DEF_RING_DEPTH = 16;
    localparam int DEF_MSG_BYTES  = 8;

    // operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_SEND     = 2'd0;
    localparam t_op OP_RECV     = 2'd1;
    localparam t_op OP_RECV_ANY = 2'd2;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_BAD_PAIR  = 3'd3;
    localparam t_status ST_TOO_LONG  = 3'd4;
    localparam t_status ST_TOO_SMALL = 3'd5;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ACTIVE_NODES  = 2'd0;
    localparam t_cfg_idx CFG_MAX_MSG_BYTES = 2'd1;

    localparam int CFG_DATA_W = 4;

    typedef struct packed {
        t_op         operation;
        logic [1:0]  src_node;
        logic [1:0]  dst_node;
        logic [3:0]  length;
        logic [63:0] payload;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [63:0] data;
        logic [3:0]  data_length;
        logic [1:0]  from_node;
    } t_result;

    typedef struct packed {
        logic [2:0] active_nodes;
        logic [3:0] max_msg_bytes;
    } t_cfg;

    // ring of an ordered pair: to*(n-1)+from, less one above the diagonal
    function automatic logic [5:0] ring_of(input logic [2:0] from, input logic [2:0] to,
                                           input logic [2:0] n);
        logic [5:0] r;
        r = {3'b000, to} * {3'b000, n - 3'd1} + {3'b000, from};
        if (from > to) begin
            r = r - 6'd1;
        end
        return r;
    endfunction

    // keep the low len bytes of a word
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (len > 4'(b)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mmrq_ptr_ram.sv
// Ring pointer memory: one head/tail entry per ring, reads zero until written.
`default_nettype none

module mmrq_ptr_ram #(
    parameter int ENTRIES = 12,
    parameter int DW      = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_we,
    input  wire logic [$clog2(ENTRIES)-1:0] i_addr,
    input  wire logic [DW-1:0]              i_wdata,
    output logic      [DW-1:0]              o_rdata
);

    logic [DW-1:0]      r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [DW-1:0]      r_rdata;
    logic               r_rvld;

    // mark entries once written, capture valid flag on reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else if (i_en) begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end else begin
                r_rvld <= r_valid[i_addr];
            end
        end
    end

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

>>> hw/rtl/mmrq_msg_ram.sv
// Message memory: length and payload word of every ring slot.
`default_nettype none

module mmrq_msg_ram #(
    parameter int ENTRIES = 192,
    parameter int DW      = 68
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_we,
    input  wire logic [$clog2(ENTRIES)-1:0] i_addr,
    input  wire logic [DW-1:0]              i_wdata,
    output logic      [DW-1:0]              o_rdata
);

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/mmrq_ctrl.sv
// Command sequencer: pointer read, message read or write, pointer write-back.
`default_nettype none
`include "mesh_mailbox_ring_queues_top_defines.svh"

module mmrq_ctrl
    import mmrq_pkg::*;
#(
    parameter int NODES      = DEF_NODES,
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int MSG_BYTES  = DEF_MSG_BYTES,
    localparam int RC        = NODES * (NODES - 1),
    localparam int RW        = $clog2(RC),
    localparam int PW        = $clog2(RING_DEPTH),
    localparam int MAW       = $clog2(RC * RING_DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    input  wire t_cmd           i_cmd,
    input  wire t_cfg           i_cfg,
    output logic                o_strobe,
    output t_result             o_result,
    output logic                o_ptr_en,
    output logic                o_ptr_we,
    output logic [RW-1:0]       o_ptr_addr,
    output logic [2*PW-1:0]     o_ptr_wdata,
    input  wire logic [2*PW-1:0] i_ptr_rdata,
    output logic                o_msg_en,
    output logic                o_msg_we,
    output logic [MAW-1:0]      o_msg_addr,
    output logic [67:0]         o_msg_wdata,
    input  wire logic [67:0]    i_msg_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PTR  = 3'b010,
        S_MSG  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic        r_strobe, n_strobe;
    t_result     r_res, n_res;
    t_op         r_op, n_op;
    logic [2:0]  r_src, n_src;
    logic [1:0]  r_dst, n_dst;
    logic [3:0]  r_len, n_len;
    logic [63:0] r_pay, n_pay;
    logic [RW-1:0] r_ring, n_ring;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;

    logic [2:0]  n_eff;
    logic [3:0]  limit;
    logic        pair_ok;
    logic [2:0]  first_src;
    logic [2:0]  nxt_src;
    logic [2:0]  sel_from;
    logic [2:0]  sel_to;
    logic [RW-1:0] ring_sel;
    logic [PW-1:0] p_head;
    logic [PW-1:0] p_tail;
    logic [3:0]  m_len;
    logic [63:0] m_data;

    function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [MAW-1:0] slot_addr(input logic [RW-1:0] ring,
                                                 input logic [PW-1:0] p);
        return MAW'(ring) * MAW'(RING_DEPTH) + MAW'(p);
    endfunction

    // clamp node count and message limit
    always_comb begin
        n_eff = i_cfg.active_nodes;
        if (int'(n_eff) > NODES) begin
            n_eff = 3'(NODES);
        end
        if (n_eff < 3'd2) begin
            n_eff = 3'd2;
        end
        limit = i_cfg.max_msg_bytes;
        if (int'(limit) > MSG_BYTES) begin
            limit = 4'(MSG_BYTES);
        end
    end

    // pick the source and ring to look at next
    always_comb begin
        pair_ok   = ({1'b0, i_cmd.src_node} < n_eff) && ({1'b0, i_cmd.dst_node} < n_eff)
                    && (i_cmd.src_node != i_cmd.dst_node);
        first_src = (i_cmd.dst_node == 2'd0) ? 3'd1 : 3'd0;
        nxt_src   = r_src + 3'd1;
        if (nxt_src == {1'b0, r_dst}) begin
            nxt_src = nxt_src + 3'd1;
        end
        if (r_state == S_IDLE) begin
            sel_from = (i_cmd.operation == OP_RECV_ANY) ? first_src : {1'b0, i_cmd.src_node};
            sel_to   = {1'b0, i_cmd.dst_node};
        end else begin
            sel_from = nxt_src;
            sel_to   = {1'b0, r_dst};
        end
        ring_sel = RW'(ring_of(sel_from, sel_to, n_eff));
    end

    assign p_head = i_ptr_rdata[2*PW-1:PW];
    assign p_tail = i_ptr_rdata[PW-1:0];
    assign m_len  = i_msg_rdata[67:64];
    assign m_data = i_msg_rdata[63:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_res       = r_res;
        n_op        = r_op;
        n_src       = r_src;
        n_dst       = r_dst;
        n_len       = r_len;
        n_pay       = r_pay;
        n_ring      = r_ring;
        n_head      = r_head;
        n_tail      = r_tail;
        o_ptr_en    = 1'b0;
        o_ptr_we    = 1'b0;
        o_ptr_addr  = r_ring;
        o_ptr_wdata = {r_head, r_tail};
        o_msg_en    = 1'b0;
        o_msg_we    = 1'b0;
        o_msg_addr  = slot_addr(r_ring, r_head);
        o_msg_wdata = {r_len, r_pay & byte_mask(r_len)};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_cmd.operation;
                    n_src = (i_cmd.operation == OP_RECV_ANY) ? first_src
                                                              : {1'b0, i_cmd.src_node};
                    n_dst = i_cmd.dst_node;
                    n_len = i_cmd.length;
                    n_pay = i_cmd.payload;
                    n_res = '0;
                    n_res.status = ST_BAD_PAIR;
                    case (i_cmd.operation)
                        OP_SEND: begin
                            if (!pair_ok) begin
                                n_strobe = 1'b1;
                            end else if (i_cmd.length > limit) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_TOO_LONG;
                            end else begin
                                o_ptr_en   = 1'b1;
                                o_ptr_addr = ring_sel;
                                n_ring     = ring_sel;
                                n_state    = S_PTR;
                            end
                        end
                        OP_RECV: begin
                            if (!pair_ok) begin
                                n_strobe = 1'b1;
                            end else begin
                                o_ptr_en   = 1'b1;
                                o_ptr_addr = ring_sel;
                                n_ring     = ring_sel;
                                n_state    = S_PTR;
                            end
                        end
                        OP_RECV_ANY: begin
                            if ({1'b0, i_cmd.dst_node} >= n_eff) begin
                                n_strobe = 1'b1;
                            end else begin
                                o_ptr_en   = 1'b1;
                                o_ptr_addr = ring_sel;
                                n_ring     = ring_sel;
                                n_state    = S_PTR;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_PTR: begin
                n_res = '0;
                if (r_op == OP_SEND) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (slot_next(p_tail) == p_head) begin
                        n_res.status = ST_FULL;
                    end else begin
                        // store message, advance tail
                        o_msg_en     = 1'b1;
                        o_msg_we     = 1'b1;
                        o_msg_addr   = slot_addr(r_ring, p_tail);
                        o_ptr_en     = 1'b1;
                        o_ptr_we     = 1'b1;
                        o_ptr_wdata  = {p_head, slot_next(p_tail)};
                        n_res.status = ST_OK;
                    end
                end else if (p_head == p_tail) begin
                    if (r_op == OP_RECV_ANY && nxt_src < n_eff) begin
                        // try the next source
                        n_src      = nxt_src;
                        o_ptr_en   = 1'b1;
                        o_ptr_addr = ring_sel;
                        n_ring     = ring_sel;
                    end else begin
                        n_strobe     = 1'b1;
                        n_res.status = ST_EMPTY;
                        n_state      = S_IDLE;
                    end
                end else begin
                    // fetch the oldest message
                    o_msg_en   = 1'b1;
                    o_msg_addr = slot_addr(r_ring, p_head);
                    n_head     = p_head;
                    n_tail     = p_tail;
                    n_state    = S_MSG;
                end
            end
            S_MSG: begin
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
                n_res             = '0;
                n_res.data_length = m_len;
                n_res.from_node   = r_src[1:0];
                if (m_len > r_len) begin
                    n_res.status = ST_TOO_SMALL;
                end else begin
                    // pop: advance head
                    o_ptr_en     = 1'b1;
                    o_ptr_we     = 1'b1;
                    o_ptr_wdata  = {slot_next(r_head), r_tail};
                    n_res.status = ST_OK;
                    n_res.data   = m_data;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // command and result holding registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_op   <= n_op;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_len  <= n_len;
        r_pay  <= n_pay;
        r_ring <= n_ring;
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `MMRQ_ASSERT(a_strobe_cause, i_clk, i_rst_n, r_strobe |-> $past(r_state != S_IDLE || i_start), "result without a request")
    `MMRQ_ASSERT(a_finish_strobe, i_clk, i_rst_n, (r_state != S_IDLE && n_state == S_IDLE) |=> r_strobe, "request finished without result")
    `MMRQ_ASSERT(a_msg_write_state, i_clk, i_rst_n, (o_msg_en && o_msg_we) |-> (r_state == S_PTR && r_op == OP_SEND), "message write outside send")
    `MMRQ_ASSERT(a_data_zero, i_clk, i_rst_n, (r_strobe && r_res.status != ST_OK) |-> (r_res.data == '0), "data on failed request")
    `MMRQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !r_strobe, "result right after reset")

endmodule

`default_nettype wire

>>> hw/rtl/mesh_mailbox_ring_queues_top.sv
// Top level of the mailbox mesh: configuration registers and memory hookup.
//
// Mailbox mesh of single-producer, single-consumer rings, one ring per ordered
// node pair. A command (send, receive from a named source, receive from any
// source) is taken when start is high and busy is low. Each command gives
// exactly one result, shown for one cycle with o_strobe high; the receiver
// cannot stall it and must take it in that cycle.
// Rejected commands give their result straight from idle; sends, and receives
// that find the ring empty, give it after the pointer read, and receives that
// read a message after the message read. Receive-any reads the pointer of each
// empty source in turn. Valid commands read the ring pointer memory, then,
// unless the ring is full or empty, read or write message memory; busy drops
// in the cycle the result is shown, so the next command overlaps it.
// Configuration writes (valid/ready, always ready) are taken at any time but
// are meant for idle periods. Reset sets 4 active nodes and an 8-byte limit;
// all rings read empty right after reset, no clearing pass is needed.
`default_nettype none

module mesh_mailbox_ring_queues_top
    import mmrq_pkg::*;
#(
    parameter int NODES      = DEF_NODES,
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int MSG_BYTES  = DEF_MSG_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_cmd                  i_cmd,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire t_cfg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RC  = NODES * (NODES - 1);
    localparam int RW  = $clog2(RC);
    localparam int PW  = $clog2(RING_DEPTH);
    localparam int MAW = $clog2(RC * RING_DEPTH);

    logic [2:0] r_active_nodes;
    logic [3:0] r_max_msg_bytes;
    t_cfg       cfg;

    logic            ptr_en;
    logic            ptr_we;
    logic [RW-1:0]   ptr_addr;
    logic [2*PW-1:0] ptr_wdata;
    logic [2*PW-1:0] ptr_rdata;
    logic            msg_en;
    logic            msg_we;
    logic [MAW-1:0]  msg_addr;
    logic [67:0]     msg_wdata;
    logic [67:0]     msg_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_nodes  <= 3'd4;
            r_max_msg_bytes <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACTIVE_NODES: begin
                    r_active_nodes <= i_cfg_data[2:0];
                end
                CFG_MAX_MSG_BYTES: begin
                    r_max_msg_bytes <= i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign cfg.active_nodes  = r_active_nodes;
    assign cfg.max_msg_bytes = r_max_msg_bytes;

    mmrq_ctrl #(
        .NODES      (NODES),
        .RING_DEPTH (RING_DEPTH),
        .MSG_BYTES  (MSG_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_cfg       (cfg),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_ptr_en    (ptr_en),
        .o_ptr_we    (ptr_we),
        .o_ptr_addr  (ptr_addr),
        .o_ptr_wdata (ptr_wdata),
        .i_ptr_rdata (ptr_rdata),
        .o_msg_en    (msg_en),
        .o_msg_we    (msg_we),
        .o_msg_addr  (msg_addr),
        .o_msg_wdata (msg_wdata),
        .i_msg_rdata (msg_rdata)
    );

    mmrq_ptr_ram #(
        .ENTRIES (RC),
        .DW      (2 * PW)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ptr_en),
        .i_we    (ptr_we),
        .i_addr  (ptr_addr),
        .i_wdata (ptr_wdata),
        .o_rdata (ptr_rdata)
    );

    mmrq_msg_ram #(
        .ENTRIES (RC * RING_DEPTH),
        .DW      (68)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_en    (msg_en),
        .i_we    (msg_we),
        .i_addr  (msg_addr),
        .i_wdata (msg_wdata),
        .o_rdata (msg_rdata)
    );

endmodule

`default_nettype wire
